/* src/utf8_stream_validator_unit_assert.svh */
// Assertion macros used by the validator top level.
`ifndef UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_UNIT_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define UTF8SV_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Checks that a trigger is followed in the next cycle by a consequence.
`define UTF8SV_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

/* src/utf8sv_pkg.sv */
// Types, codes and helper functions shared by the UTF-8 validator modules.
package utf8sv_pkg;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_TRUNCATED  = 3'd1;
   localparam logic [2:0] ERR_STRAY      = 3'd2;
   localparam logic [2:0] ERR_BAD_LENGTH = 3'd3;
   localparam logic [2:0] ERR_BAD_TRAIL  = 3'd4;
   localparam logic [2:0] ERR_OVERLONG   = 3'd5;

   localparam logic [7:0] REPLACEMENT_RESET = 8'd63;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic        wait_more;
      logic [20:0] code_point;
      logic [2:0]  length;
      logic [2:0]  error_code;
   } decode_type;

   // Sequence length announced by a lead byte, zero for bytes that cannot lead.
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      begin
         if (b[7] == 1'b0) len = 3'd1;
         else if (b[7:5] == 3'b110) len = 3'd2;
         else if (b[7:4] == 4'b1110) len = 3'd3;
         else if (b[7:3] == 5'b11110) len = 3'd4;
         else len = 3'd0;
         return len;
      end
   endfunction

endpackage

/* src/utf8sv_decoder.sv */
// Shared decode unit: judges the character that starts at the head of the window.
module utf8sv_decoder
   import utf8sv_pkg::*;
(
   input  logic [3:0][7:0] window,
   input  logic [2:0]      avail,
   input  logic            eos,
   output decode_type      result
);

   logic [7:0] lead;
   logic [2:0] len;
   logic       trail_ok;
   logic       wide_enough;

   always_comb begin
      lead        = window[0];
      len         = lead_length(lead);
      result      = '0;
      trail_ok    = 1'b1;
      wide_enough = 1'b1;
      if (len == 3'd0) begin
         result.length     = 3'd1;
         result.error_code = (lead[7:6] == 2'b10) ? ERR_STRAY : ERR_BAD_LENGTH;
      end else if (len > avail) begin
         result.length = 3'd1;
         if (eos) begin
            result.error_code = ERR_TRUNCATED;
         end else begin
            result.wait_more = 1'b1;
         end
      end else begin
         case (len)
            3'd1: begin
               result.code_point = {14'd0, lead[6:0]};
            end
            3'd2: begin
               result.code_point = {10'd0, lead[4:0], window[1][5:0]};
               trail_ok          = (window[1][7:6] == 2'b10);
               wide_enough       = (lead[4:1] != 4'd0);
            end
            3'd3: begin
               result.code_point = {5'd0, lead[3:0], window[1][5:0], window[2][5:0]};
               trail_ok          = (window[1][7:6] == 2'b10) && (window[2][7:6] == 2'b10);
               wide_enough       = (lead[3:0] != 4'd0) || window[1][5];
            end
            default: begin
               result.code_point = {lead[2:0], window[1][5:0], window[2][5:0],
                                    window[3][5:0]};
               trail_ok          = (window[1][7:6] == 2'b10) && (window[2][7:6] == 2'b10)
                                   && (window[3][7:6] == 2'b10);
               wide_enough       = (lead[2:0] != 3'd0) || (window[1][5:4] != 2'd0);
            end
         endcase
         if (!trail_ok) begin
            result.length     = 3'd1;
            result.error_code = ERR_BAD_TRAIL;
         end else if (!wide_enough) begin
            result.length     = 3'd1;
            result.error_code = ERR_OVERLONG;
         end else begin
            result.length     = len;
            result.error_code = ERR_NONE;
         end
      end
   end

endmodule

/* src/utf8sv_csr.sv */
// Configuration register file with an APB-style access port.
module utf8sv_csr
   import utf8sv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  replacement_byte
);

   logic [7:0] replacement_ff;
   logic [7:0] replacement_in;

   always_comb begin
      replacement_in = replacement_ff;
      if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
         replacement_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         replacement_ff <= REPLACEMENT_RESET;
      end else begin
         replacement_ff <= replacement_in;
      end
   end

   assign prdata           = (paddr[2] == 1'b0) ? {24'd0, replacement_ff} : 32'd0;
   assign pready           = 1'b1;
   assign replacement_byte = replacement_ff;

endmodule

/* src/utf8_stream_validator_unit.sv */
// Top level of the streaming UTF-8 decoder and validator.
//
// The req channel carries one raw byte per word plus a flag on the last byte
// of a string. The rsp channel gives one word per decoded character or per
// rejected byte: code point (or the replacement byte), length, error code,
// lead byte, running error count and a flag on the last word an input caused.
// Both channels use valid/ready; the APB-style port holds the replacement
// byte at address 0.
//
// Flow: a byte is taken while the sequencer is idle; the shared decode unit
// then runs once per cycle on the buffered window while the output register
// can take a word, producing one result word per pass that does not wait for
// more bytes. A byte that only extends a partial character gives no word; a
// byte that completes a character or triggers a replay gives up to four
// result words. A byte dropped while the string is halted starts no pass.
// The output register lets the next byte be taken while the last word still
// waits. When the receiver stalls, the sequencer holds its pass until the
// output register frees up, and no byte is taken until the pass completes.
// Synchronous reset empties the buffer, clears the error count and the halt
// flag, and restores the replacement byte to 63. No clearing pass runs.
module utf8_stream_validator_unit
   import utf8sv_pkg::*;
#(
   parameter int ERROR_COUNT_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic [2:0]  rsp_char_length,
   output logic [2:0]  rsp_error_code,
   output logic [7:0]  rsp_first_byte,
   output logic [15:0] rsp_errors_so_far,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   `include "utf8_stream_validator_unit_assert.svh"

   // Sequencer state and the byte window. The window doubles as the pending
   // buffer: bytes waiting for the rest of their character stay at its head.
   state_type                   state_ff, state_in;
   logic [3:0][7:0]             work_ff, work_in;
   logic [2:0]                  cnt_ff, cnt_in;
   logic                        eos_ff, eos_in;
   logic                        halted_ff, halted_in;
   logic [ERROR_COUNT_BITS-1:0] tally_ff, tally_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic [20:0] out_cp_ff, out_cp_in;
   logic [2:0]  out_len_ff, out_len_in;
   logic [2:0]  out_err_ff, out_err_in;
   logic [7:0]  out_first_ff, out_first_in;
   logic [15:0] out_count_ff, out_count_in;
   logic        out_last_ff, out_last_in;

   logic                        accept;
   logic                        advance;
   logic                        finish;
   logic [7:0]                  replacement_byte;
   decode_type                  dec;
   logic [2:0]                  consumed;
   logic [2:0]                  remaining;
   logic [3:0][7:0]             shifted;
   logic [2:0]                  next_len;
   logic [ERROR_COUNT_BITS-1:0] tally_next;
   logic [ERROR_COUNT_BITS+15:0] tally_wide;
   logic                        halt_now;
   int                          src;

   utf8sv_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .replacement_byte (replacement_byte)
   );

   utf8sv_decoder u_decoder (
      .window (work_ff),
      .avail  (cnt_ff),
      .eos    (eos_ff),
      .result (dec)
   );

   // Handshake outputs of the sequencer.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      advance   = (state_ff == ST_RUN) && (!out_valid_ff || rsp_ready);
   end

   // Bytes left after this pass, the window shifted past the bytes it consumes,
   // the new error count, and whether this pass gives the last word for the current input byte.
   always_comb begin
      consumed = (dec.error_code != ERR_NONE) ? 3'd1 : dec.length;
      remaining = cnt_ff - consumed;
      for (int i = 0; i < 4; i++) begin
         src = i + int'(consumed);
         shifted[i] = (src < 4) ? work_ff[src[1:0]] : 8'd0;
      end
      next_len = lead_length(shifted[0]);
      tally_next = tally_ff;
      if ((dec.error_code != ERR_NONE) && (tally_ff != {ERROR_COUNT_BITS{1'b1}})) begin
         tally_next = tally_ff + ERROR_COUNT_BITS'(1);
      end
      halt_now = (dec.error_code != ERR_NONE) && (replacement_byte == 8'd0);
      finish   = halt_now || (remaining == 3'd0) ||
                 (!eos_ff && (next_len != 3'd0) && (next_len > remaining));
      if (dec.wait_more) begin
         finish = 1'b1;
      end
      tally_wide = {16'd0, tally_next};
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !halted_ff) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (advance && finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Window, counters and output register.
   always_comb begin
      work_in      = work_ff;
      cnt_in       = cnt_ff;
      eos_in       = eos_ff;
      halted_in    = halted_ff;
      tally_in     = tally_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_cp_in    = out_cp_ff;
      out_len_in   = out_len_ff;
      out_err_in   = out_err_ff;
      out_first_in = out_first_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;

      if (accept) begin
         if (halted_ff) begin
            // While halted, bytes are dropped; the end of the string lifts it.
            if (req_end_of_string) begin
               halted_in = 1'b0;
               tally_in  = '0;
               cnt_in    = 3'd0;
            end
         end else begin
            work_in[cnt_ff[1:0]] = req_data_byte;
            cnt_in               = cnt_ff + 3'd1;
            eos_in               = req_end_of_string;
         end
      end

      if (advance && !dec.wait_more) begin
         out_valid_in = 1'b1;
         out_cp_in    = (dec.error_code != ERR_NONE) ? {13'd0, replacement_byte}
                                                     : dec.code_point;
         out_len_in   = consumed;
         out_err_in   = dec.error_code;
         out_first_in = work_ff[0];
         out_count_in = tally_wide[15:0];
         out_last_in  = finish;
         tally_in     = tally_next;
         work_in      = shifted;
         cnt_in       = remaining;
         if (halt_now) begin
            // A zero replacement drops everything still buffered.
            halted_in = !eos_ff;
            cnt_in    = 3'd0;
         end
         if (finish && eos_ff) begin
            cnt_in   = 3'd0;
            tally_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 3'd0;
         halted_ff    <= 1'b0;
         tally_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         halted_ff    <= halted_in;
         tally_ff     <= tally_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      eos_ff       <= eos_in;
      out_cp_ff    <= out_cp_in;
      out_len_ff   <= out_len_in;
      out_err_ff   <= out_err_in;
      out_first_ff <= out_first_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_code_point    = out_cp_ff;
   assign rsp_char_length   = out_len_ff;
   assign rsp_error_code    = out_err_ff;
   assign rsp_first_byte    = out_first_ff;
   assign rsp_errors_so_far = out_count_ff;
   assign rsp_last_of_run   = out_last_ff;

   // A partial character never holds more than three bytes between inputs.
   `UTF8SV_ASSERT(a_idle_pending_fits, (state_ff != ST_IDLE) || (cnt_ff <= 3'd3),
      "pending buffer overfull while idle")
   // A byte taken while halted never starts a decode pass.
   `UTF8SV_ASSERT_NEXT(a_halted_drops, accept && halted_ff, state_ff == ST_IDLE,
      "decode pass started while halted")
   // A byte taken while running normally always starts a decode pass.
   `UTF8SV_ASSERT_NEXT(a_accept_runs, accept && !halted_ff, state_ff == ST_RUN,
      "accepted byte did not start a decode pass")
   // Rejected bytes are always reported as one byte long.
   `UTF8SV_ASSERT(a_error_len_one,
      !out_valid_ff || (out_err_ff == ERR_NONE) || (out_len_ff == 3'd1),
      "error result with length other than one")

endmodule
